### src/mrlb_pkg.sv
// Shared types, codes and sizes for the multi-ring log buffer.
// No dependencies; imported by the controller, the datapath and the top level.
package mrlb_pkg;

   // Size of the byte store and the largest number of rings it can be split into
   localparam int STORE_BYTES    = 8192;
   localparam int MAX_RINGS      = 4;
   localparam int STORE_AW       = $clog2(STORE_BYTES);

   // Widths that are fixed by the interface fields
   localparam int RING_W         = 2;
   localparam int PTR_W          = 13;
   localparam int SUM_W          = 32;
   localparam int CSR_W          = 14;
   localparam int CSR_IDX_W      = 2;
   localparam int COUNT_W        = 3;
   localparam int ADDR_CALC_W    = RING_W + CSR_W;
   localparam int CFG_PROD_W     = COUNT_W + CSR_W;

   localparam int RING_BYTES_MIN = 4;
   localparam int RING_BYTES_MAX = 8192;

   // Configuration reset values
   localparam logic [COUNT_W-1:0] RING_COUNT_RST  = 3'd1;
   localparam logic [CSR_W-1:0]   RING_BYTES_RST  = 14'd8192;
   localparam logic [RING_W-1:0]  ACTIVE_RING_RST = 2'd0;

   // Request codes
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;
   localparam logic [1:0] REQ_NOP   = 2'd3;

   // Status codes
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_EMPTY  = 2'd1;
   localparam logic [1:0] STAT_BAD_ID = 2'd2;
   localparam logic [1:0] STAT_BAD_CFG = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RING_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RING_BYTES  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_RING = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // capture request, launch the store read
      logic commit;  // apply the update and load the result register
   } mrlb_cmd_type;

endpackage

### src/mrlb_ctrl.sv
// Sequencing for the multi-ring log buffer: accept, execute, hand off result.
// Depends on mrlb_pkg.
module mrlb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mrlb_pkg::mrlb_cmd_type cmd
);
   import mrlb_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd.load     = (state_ff == S_IDLE) && req_valid;
      cmd.commit   = (state_ff == S_EXEC) && slot_free;
      state_in     = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.load) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (cmd.commit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### src/mrlb_dp.sv
// Datapath of the multi-ring log buffer: config registers, ring pointers,
// checksums, the byte store and the result register. Depends on mrlb_pkg.
module mrlb_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  mrlb_pkg::mrlb_cmd_type           cmd,
   input  logic                             csr_write_en,
   input  logic [mrlb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mrlb_pkg::CSR_W-1:0]       csr_wdata,
   input  logic [1:0]                       req_type,
   input  logic [7:0]                       req_byte_value,
   input  logic                             req_use_active,
   input  logic [mrlb_pkg::RING_W-1:0]      req_ring_select,
   output logic [1:0]                       rsp_status,
   output logic [7:0]                       rsp_byte_read,
   output logic                             rsp_byte_stored,
   output logic                             rsp_ring_has_data,
   output logic [mrlb_pkg::SUM_W-1:0]       rsp_ring_sum,
   output logic [mrlb_pkg::PTR_W-1:0]       rsp_ring_fill
);
   import mrlb_pkg::*;

   // Configuration
   logic [COUNT_W-1:0] ring_count_ff, ring_count_in;
   logic [CSR_W-1:0]   ring_bytes_ff, ring_bytes_in;
   logic [RING_W-1:0]  active_ring_ff, active_ring_in;

   // Ring state; wrapped marks a ring whose head has gone all the way round since
   // the last clear, so every byte in its region has been written
   logic [PTR_W-1:0] head_ff [MAX_RINGS];
   logic [PTR_W-1:0] head_in [MAX_RINGS];
   logic [PTR_W-1:0] tail_ff [MAX_RINGS];
   logic [PTR_W-1:0] tail_in [MAX_RINGS];
   logic [SUM_W-1:0] sum_ff  [MAX_RINGS];
   logic [SUM_W-1:0] sum_in  [MAX_RINGS];
   logic [MAX_RINGS-1:0] wrapped_ff, wrapped_in;

   // Captured request
   logic [1:0]          op_ff;
   logic [7:0]          val_ff;
   logic [RING_W-1:0]   ring_ff;
   logic [STORE_AW-1:0] addr_ff;

   // Byte store
   logic [7:0] store_mem [STORE_BYTES];
   logic [7:0] rdata_ff;
   logic       mem_we;

   // Result register
   logic [1:0]       status_ff, status_in;
   logic [7:0]       byte_read_ff, byte_read_in;
   logic             stored_ff, stored_in;
   logic             has_ff, has_in;
   logic [SUM_W-1:0] rsum_ff, rsum_in;
   logic [PTR_W-1:0] fill_ff, fill_in;

   // Request decode at accept time
   logic [RING_W-1:0]      sel_ring;
   logic [PTR_W-1:0]       sel_ptr;
   logic [ADDR_CALC_W-1:0] addr_calc;

   logic [CFG_PROD_W-1:0] layout_bytes;
   logic                  cfg_ok;
   logic                  csr_clear;
   logic                  clear_all;

   function automatic logic [PTR_W-1:0] fill_of(input logic [PTR_W-1:0] h,
                                                input logic [PTR_W-1:0] t,
                                                input logic [CSR_W-1:0] bytes);
      logic [CSR_W-1:0] d;
      if (h >= t) begin
         d = CSR_W'(h) - CSR_W'(t);
      end else begin
         d = bytes - CSR_W'(t) + CSR_W'(h);
      end
      return d[PTR_W-1:0];
   endfunction

   // ---------------- configuration ----------------
   always_comb begin
      ring_count_in  = ring_count_ff;
      ring_bytes_in  = ring_bytes_ff;
      active_ring_in = active_ring_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_RING_COUNT:  ring_count_in  = csr_wdata[COUNT_W-1:0];
            CSR_RING_BYTES:  ring_bytes_in  = csr_wdata;
            CSR_ACTIVE_RING: active_ring_in = csr_wdata[RING_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_clear = csr_write_en &&
                      ((csr_index == CSR_RING_COUNT) || (csr_index == CSR_RING_BYTES));

   assign layout_bytes = CFG_PROD_W'(ring_count_ff) * CFG_PROD_W'(ring_bytes_ff);

   assign cfg_ok = (ring_count_ff != '0) &&
                   (32'(ring_count_ff) <= MAX_RINGS) &&
                   (ring_bytes_ff >= CSR_W'(RING_BYTES_MIN)) &&
                   (ring_bytes_ff <= CSR_W'(RING_BYTES_MAX)) &&
                   (ring_bytes_ff[1:0] == 2'b00) &&
                   (layout_bytes <= CFG_PROD_W'(STORE_BYTES)) &&
                   (COUNT_W'(active_ring_ff) < ring_count_ff);

   // ---------------- accept: pick ring and store address ----------------
   always_comb begin
      if ((req_type == REQ_READ) && !req_use_active) begin
         sel_ring = req_ring_select;
      end else begin
         sel_ring = active_ring_ff;
      end
      if (req_type == REQ_READ) begin
         sel_ptr = tail_ff[sel_ring];
      end else begin
         sel_ptr = head_ff[sel_ring];
      end
      addr_calc = (ADDR_CALC_W'(sel_ring) * ADDR_CALC_W'(ring_bytes_ff)) +
                  ADDR_CALC_W'(sel_ptr);
   end

   // ---------------- execute ----------------
   always_comb begin
      logic [PTR_W-1:0] h;
      logic [PTR_W-1:0] t;
      logic [CSR_W-1:0] nh_wide;
      logic [PTR_W-1:0] nh;
      logic             head_wrap;
      logic [CSR_W-1:0] nt_wide;
      logic [PTR_W-1:0] nt;
      logic [CSR_W-1:0] rt_wide;
      logic [PTR_W-1:0] rt;
      logic [7:0]       old_byte;
      logic             report;

      h         = head_ff[ring_ff];
      t         = tail_ff[ring_ff];
      nh_wide   = CSR_W'(h) + 1'b1;
      head_wrap = (nh_wide >= ring_bytes_ff);
      nh        = head_wrap ? '0 : nh_wide[PTR_W-1:0];
      nt_wide   = CSR_W'(nh) + 1'b1;
      nt        = (nt_wide >= ring_bytes_ff) ? '0 : nt_wide[PTR_W-1:0];
      rt_wide   = CSR_W'(t) + 1'b1;
      rt        = (rt_wide >= ring_bytes_ff) ? '0 : rt_wide[PTR_W-1:0];
      // a slot not yet reached since the last clear is taken as zero
      old_byte  = wrapped_ff[ring_ff] ? rdata_ff : 8'd0;

      clear_all    = csr_clear || (cmd.commit && (op_ff == REQ_CLEAR));
      head_in      = head_ff;
      tail_in      = tail_ff;
      sum_in       = sum_ff;
      wrapped_in   = wrapped_ff;
      status_in    = STAT_OK;
      byte_read_in = 8'd0;
      stored_in    = 1'b0;
      mem_we       = 1'b0;
      report       = 1'b0;

      if (clear_all) begin
         for (int i = 0; i < MAX_RINGS; i++) begin
            head_in[i] = '0;
            tail_in[i] = '0;
            sum_in[i]  = '0;
         end
         wrapped_in = '0;
      end else if (cmd.commit) begin
         if (!cfg_ok) begin
            status_in = STAT_BAD_CFG;
         end else begin
            case (op_ff)
               REQ_WRITE: begin
                  report = 1'b1;
                  if (val_ff != 8'd0) begin
                     sum_in[ring_ff]  = sum_ff[ring_ff] + SUM_W'(val_ff) - SUM_W'(old_byte);
                     head_in[ring_ff] = nh;
                     if (t == nh) tail_in[ring_ff] = nt;
                     if (head_wrap) wrapped_in[ring_ff] = 1'b1;
                     stored_in = 1'b1;
                     mem_we    = 1'b1;
                  end
               end
               REQ_READ: begin
                  if (COUNT_W'(ring_ff) >= ring_count_ff) begin
                     status_in = STAT_BAD_ID;
                  end else begin
                     report = 1'b1;
                     if (h == t) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        byte_read_in     = rdata_ff;
                        tail_in[ring_ff] = rt;
                     end
                  end
               end
               default: report = 1'b1;
            endcase
         end
      end

      rsum_in = report ? sum_in[ring_ff] : '0;
      fill_in = report ? fill_of(head_in[ring_ff], tail_in[ring_ff], ring_bytes_ff) : '0;
      has_in  = cfg_ok && (head_in[active_ring_ff] != tail_in[active_ring_ff]);
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_count_ff  <= RING_COUNT_RST;
         ring_bytes_ff  <= RING_BYTES_RST;
         active_ring_ff <= ACTIVE_RING_RST;
         for (int i = 0; i < MAX_RINGS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            sum_ff[i]  <= '0;
         end
         wrapped_ff <= '0;
      end else begin
         ring_count_ff  <= ring_count_in;
         ring_bytes_ff  <= ring_bytes_in;
         active_ring_ff <= active_ring_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         sum_ff         <= sum_in;
         wrapped_ff     <= wrapped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_type;
         val_ff  <= req_byte_value;
         ring_ff <= sel_ring;
         addr_ff <= addr_calc[STORE_AW-1:0];
      end
      if (cmd.commit) begin
         status_ff    <= status_in;
         byte_read_ff <= byte_read_in;
         stored_ff    <= stored_in;
         has_ff       <= has_in;
         rsum_ff      <= rsum_in;
         fill_ff      <= fill_in;
      end
   end

   // single store: read on accept, write back on commit
   always_ff @(posedge clock) begin
      if (mem_we) store_mem[addr_ff] <= val_ff;
      if (cmd.load) rdata_ff <= store_mem[addr_calc[STORE_AW-1:0]];
   end

   assign rsp_status        = status_ff;
   assign rsp_byte_read     = byte_read_ff;
   assign rsp_byte_stored   = stored_ff;
   assign rsp_ring_has_data = has_ff;
   assign rsp_ring_sum      = rsum_ff;
   assign rsp_ring_fill     = fill_ff;

endmodule

### src/multi_ring_log_buffer.sv
// Top level of the multi-ring log buffer: controller plus datapath.
// Depends on mrlb_pkg, mrlb_ctrl and mrlb_dp.
//
// Usage:
//   Request channel (req_*): valid/ready; one transaction is a write, read,
//   clear or no-op request. Result channel (rsp_*): valid/ready; exactly one
//   result transaction per request, in order.
//   Config port (csr_*): write-only, one register per cycle, taken whenever
//   csr_write_en is high; write it only while no request is in flight.
//   Writing ring count or ring size clears all rings in that cycle.
// Request sequence:
//   Each request runs in turn: the store read issued at accept, then the
//   update, write-back and result load. This single-port read-modify-write
//   of the byte store keeps a new request out until the last one is through.
// Reset (synchronous): rings empty, checksums zero, ring count 1, ring size
//   8192, active ring 0. No clearing pass: slots not yet written since a
//   clear read as zero through per-ring wrap flags.
// Stall: a finished result waits in the output register; the block holds the
//   next request in its execute step until that register is taken.
module multi_ring_log_buffer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_type,
   input  logic [7:0]                       req_byte_value,
   input  logic                             req_use_active,
   input  logic [mrlb_pkg::RING_W-1:0]      req_ring_select,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic [7:0]                       rsp_byte_read,
   output logic                             rsp_byte_stored,
   output logic                             rsp_ring_has_data,
   output logic [mrlb_pkg::SUM_W-1:0]       rsp_ring_sum,
   output logic [mrlb_pkg::PTR_W-1:0]       rsp_ring_fill,
   input  logic                             csr_write_en,
   input  logic [mrlb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mrlb_pkg::CSR_W-1:0]       csr_wdata
);
   import mrlb_pkg::*;

   mrlb_cmd_type cmd;

   mrlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   mrlb_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_type          (req_type),
      .req_byte_value    (req_byte_value),
      .req_use_active    (req_use_active),
      .req_ring_select   (req_ring_select),
      .rsp_status        (rsp_status),
      .rsp_byte_read     (rsp_byte_read),
      .rsp_byte_stored   (rsp_byte_stored),
      .rsp_ring_has_data (rsp_ring_has_data),
      .rsp_ring_sum      (rsp_ring_sum),
      .rsp_ring_fill     (rsp_ring_fill)
   );

`ifndef SYNTHESIS
   // a result is only loaded into a free output slot
   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over an untaken result");

   // every commit presents a result on the next cycle
   a_commit_presents: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("committed result not presented");

   // an accepted request blocks intake for its execute step
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!req_ready && !cmd.load))
      else $error("request accepted while another is in execution");
`endif

endmodule
